### rtl/core/positional_array_list_core_defines.svh
`ifndef POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PAL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PAL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pal_pkg.sv
package pal_pkg;

  localparam int DEF_CAPACITY      = 512;
  localparam int DEF_ELEMENT_WIDTH = 32;

  // Transaction field widths
  localparam int KIND_W   = 3;
  localparam int POS_W    = 9;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 10;

  // tdata layouts, first field in the low bits
  localparam int IN_KIND_LSB  = 0;
  localparam int IN_POS_LSB   = IN_KIND_LSB + KIND_W;
  localparam int IN_VAL_LSB   = IN_POS_LSB + POS_W;
  localparam int IN_TDATA_W   = ((IN_VAL_LSB + VALUE_W + 7) / 8) * 8;

  localparam int OUT_ST_LSB   = 0;
  localparam int OUT_ELEM_LSB = OUT_ST_LSB + STATUS_W;
  localparam int OUT_CNT_LSB  = OUT_ELEM_LSB + VALUE_W;
  localparam int OUT_TDATA_W  = ((OUT_CNT_LSB + COUNT_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_END   = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_REM_FRONT = 3'd3,
    KIND_REM_END   = 3'd4,
    KIND_REM_POS   = 3'd5,
    KIND_READ      = 3'd6
  } pal_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pal_status_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_UP,
    SH_DOWN
  } pal_shift_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH
  } pal_state_e;

  // Broadcast to every cell
  typedef struct packed {
    pal_shift_e shift;
    logic       tap_load;
    logic       tap_shift;
  } pal_cell_ctl_t;

  function automatic int pal_count_w(input int cap);
    return $clog2(cap + 1);
  endfunction

  // Index compare width: wide enough for the count and for the position field
  function automatic int pal_idx_w(input int cap);
    int cw;
    cw = $clog2(cap + 1);
    return (cw > POS_W) ? cw : POS_W;
  endfunction

endpackage

### rtl/core/pal_cell.sv
module pal_cell import pal_pkg::*; #(
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic                     clk,
  input  pal_cell_ctl_t            ctl,
  input  logic                     at_idx,
  input  logic                     past_idx,
  input  logic [ELEMENT_WIDTH-1:0] ins_value,
  input  logic [ELEMENT_WIDTH-1:0] below_entry,
  input  logic [ELEMENT_WIDTH-1:0] above_entry,
  input  logic [ELEMENT_WIDTH-1:0] above_tap,
  output logic [ELEMENT_WIDTH-1:0] entry,
  output logic [ELEMENT_WIDTH-1:0] tap
);

  // list slot: opens a gap or closes one at the target index
  always_ff @(posedge clk) begin
    case (ctl.shift)
      SH_UP: begin
        if (at_idx) begin
          entry <= ins_value;
        end else if (past_idx) begin
          entry <= below_entry;
        end
      end
      SH_DOWN: begin
        if (at_idx || past_idx) begin
          entry <= above_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // readout chain: snapshot of the slot, then moves toward cell 0
  always_ff @(posedge clk) begin
    if (ctl.tap_load) begin
      tap <= entry;
    end else if (ctl.tap_shift) begin
      tap <= above_tap;
    end
  end

endmodule

### rtl/core/pal_ctrl.sv
module pal_ctrl import pal_pkg::*; #(
  parameter  int CAPACITY      = DEF_CAPACITY,
  parameter  int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
  localparam int CW            = pal_count_w(CAPACITY),
  localparam int IW            = pal_idx_w(CAPACITY),
  localparam int SW            = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [KIND_W-1:0]        kind,
  input  logic [POS_W-1:0]         position,
  input  logic [ELEMENT_WIDTH-1:0] tap_head,
  output pal_cell_ctl_t            cell_ctl,
  output logic [IW-1:0]            idx,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [STATUS_W-1:0]      status,
  output logic [VALUE_W-1:0]       element_out,
  output logic [COUNT_W-1:0]       count_after
);

  pal_state_e  state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] scan_cnt, scan_cnt_next;
  pal_status_e res_status, res_status_next;
  logic [CW-1:0] res_count, res_count_next;
  logic        res_fetch, res_fetch_next;
  logic        out_load;

  logic [IW-1:0] cnt_x, pos_x, op_idx;
  logic          is_ins, is_rem, is_read;
  pal_status_e   op_status;
  logic          accept, op_ok;

  assign cnt_x    = IW'(count);
  assign pos_x    = IW'(position);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign idx      = op_idx;

  // operation decode
  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_read = 1'b0;
    op_idx  = '0;
    unique case (pal_kind_e'(kind))
      KIND_INS_FRONT: begin is_ins = 1'b1; op_idx = '0;                    end
      KIND_INS_END:   begin is_ins = 1'b1; op_idx = cnt_x;                 end
      KIND_INS_POS:   begin is_ins = 1'b1; op_idx = pos_x;                 end
      KIND_REM_FRONT: begin is_rem = 1'b1; op_idx = '0;                    end
      KIND_REM_END:   begin is_rem = 1'b1; op_idx = cnt_x - IW'(1);        end
      KIND_REM_POS:   begin is_rem = 1'b1; op_idx = pos_x;                 end
      KIND_READ:      begin is_read = 1'b1; op_idx = pos_x;                end
      default: begin
      end
    endcase

    op_status = ST_OK;
    if (is_ins) begin
      if (count == CW'(CAPACITY)) begin
        op_status = ST_FULL;
      end else if (op_idx > cnt_x) begin
        op_status = ST_RANGE;
      end
    end else if (is_rem || is_read) begin
      if (count == '0) begin
        op_status = ST_EMPTY;
      end else if (op_idx >= cnt_x) begin
        op_status = ST_RANGE;
      end
    end
    op_ok = (op_status == ST_OK);
  end

  // next state and outputs
  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_cnt_next   = scan_cnt;
    res_status_next = res_status;
    res_count_next  = res_count;
    res_fetch_next  = res_fetch;
    out_load        = 1'b0;
    cell_ctl        = '{shift: SH_HOLD, tap_load: 1'b0, tap_shift: 1'b0};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_ok && is_ins) begin
            cell_ctl.shift = SH_UP;
            count_next     = count + CW'(1);
          end else if (op_ok && is_rem) begin
            cell_ctl.shift = SH_DOWN;
            count_next     = count - CW'(1);
          end
          res_status_next   = op_status;
          res_count_next    = count_next;
          res_fetch_next    = op_ok && (is_rem || is_read);
          cell_ctl.tap_load = op_ok && (is_rem || is_read);
          scan_cnt_next     = SW'(op_idx);
          state_next        = (op_ok && (is_rem || is_read)) ? S_SCAN : S_PUSH;
        end
      end
      S_SCAN: begin
        if (scan_cnt == '0) begin
          state_next = S_PUSH;
        end else begin
          cell_ctl.tap_shift = 1'b1;
          scan_cnt_next      = scan_cnt - SW'(1);
        end
      end
      S_PUSH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt   <= scan_cnt_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
    res_fetch  <= res_fetch_next;
    if (out_load) begin
      status      <= res_status;
      element_out <= res_fetch ? VALUE_W'(tap_head) : '0;
      count_after <= COUNT_W'(res_count);
    end
  end

endmodule

### rtl/core/positional_array_list_core.sv
// Positional array list: an ordered list held packed from index 0, with
// insert/remove at front, end or any position, and read at a position.
//
// Input channel s_*: one transaction per operation (kind, position, value).
// Output channel m_*: exactly one transaction per operation, giving status
// (ok, full, empty, out of range), the removed or read element (zero on
// inserts and on failures) and the entry count after the operation.
// A failing operation leaves the list untouched.
//
// Path, from input handshake to m_tvalid: inserts, failed operations and
// the unused kind go from S_IDLE to S_PUSH, which loads the output register;
// a remove or read first passes through S_SCAN. One operation is in
// flight at a time; the next input is taken in the cycle after the
// result is loaded. S_SCAN uses the readout chain: each cell's entry is
// snapshotted and walked one cell per cycle down to cell 0.
// Inserts and removes move all cells at once in the accept cycle.
//
// Reset (rst, synchronous) empties the list and drops m_tvalid; cell storage
// is not cleared. A stalled receiver holds the result in the output
// register while the next input transaction is still taken.
module positional_array_list_core import pal_pkg::*; #(
  parameter int CAPACITY      = DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // kind [2:0], position [11:3], element_value [43:12], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status [1:0], element_out [33:2], count_after [43:34], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW = pal_idx_w(CAPACITY);

  pal_cell_ctl_t              cell_ctl;
  logic [IW-1:0]              idx;
  logic [ELEMENT_WIDTH-1:0]   ins_value;
  logic [ELEMENT_WIDTH-1:0]   entries [CAPACITY];
  logic [ELEMENT_WIDTH-1:0]   taps    [CAPACITY];
  logic [STATUS_W-1:0]        status;
  logic [VALUE_W-1:0]         element_out;
  logic [COUNT_W-1:0]         count_after;

  // inserted element trimmed or zero-extended to storage width
  assign ins_value = ELEMENT_WIDTH'(s_tdata[IN_VAL_LSB +: VALUE_W]);

  pal_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .kind        (s_tdata[IN_KIND_LSB +: KIND_W]),
    .position    (s_tdata[IN_POS_LSB +: POS_W]),
    .tap_head    (taps[0]),
    .cell_ctl    (cell_ctl),
    .idx         (idx),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .status      (status),
    .element_out (element_out),
    .count_after (count_after)
  );

  // Row of cells; cell i holds list index i.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IW-1:0] CELL_IDX = IW'(i);
    logic [ELEMENT_WIDTH-1:0] below_entry;
    logic [ELEMENT_WIDTH-1:0] above_entry;
    logic [ELEMENT_WIDTH-1:0] above_tap;

    if (i == 0) begin : g_first
      assign below_entry = '0;
    end else begin : g_inner_lo
      assign below_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign above_entry = '0;
      assign above_tap   = '0;
    end else begin : g_inner_hi
      assign above_entry = entries[i+1];
      assign above_tap   = taps[i+1];
    end

    pal_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .at_idx      (idx == CELL_IDX),
      .past_idx    (idx < CELL_IDX),
      .ins_value   (ins_value),
      .below_entry (below_entry),
      .above_entry (above_entry),
      .above_tap   (above_tap),
      .entry       (entries[i]),
      .tap         (taps[i])
    );
  end

  assign m_tdata = OUT_TDATA_W'({count_after, element_out, status});

endmodule

### rtl/core/pal_checker.sv
`include "positional_array_list_core_defines.svh"

module pal_checker import pal_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_elem;
  logic [COUNT_W-1:0]  out_count;

  assign out_status = m_tdata[OUT_ST_LSB +: STATUS_W];
  assign out_elem   = m_tdata[OUT_ELEM_LSB +: VALUE_W];
  assign out_count  = m_tdata[OUT_CNT_LSB +: COUNT_W];

  `PAL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
  `PAL_ASSERT_IMPL(a_fail_zero, m_tvalid && (out_status != ST_OK), out_elem == '0, "failed op returned an element")
  `PAL_ASSERT_IMPL(a_count_cap, m_tvalid, 32'(out_count) <= 32'(CAPACITY), "count beyond capacity")
  `PAL_ASSERT_NEXT(a_one_op, s_tvalid && s_tready, !s_tready, "second transaction taken while one in flight")

endmodule

bind positional_array_list_core pal_checker #(.CAPACITY(CAPACITY)) u_pal_checker (.*);
